### rtl/core/ahkc_pkg.sv
package ahkc_pkg;

    localparam int unsigned FRAC_BITS = 16;
    localparam logic [26:0] DB_PER_OCTAVE_Q24 = 27'd101008905;
    localparam logic [29:0] LOG2_TEN_OVER_20_Q32 = 30'd713378626;
    localparam logic signed [31:0] LEVEL_FLOOR_Q24 = -32'sd1677721600;
    localparam logic [30:0] GAIN_ONE_Q30 = 31'h4000_0000;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_INV_RATIO = 3'd1,
        REG_MAKEUP    = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_RELEASE   = 3'd4
    } ahkc_reg_t;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [15:0]        inv_ratio;
        logic [15:0]        mkup_gain;
        logic [23:0]        atk_coef;
        logic [23:0]        rel_coef;
    } ahkc_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ahkc_q_status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ahkc_q_ctrl_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_LOG,
        F_SCALE,
        F_PUSH
    } ahkc_front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ENV1,
        B_ENV2,
        B_ENV3,
        B_RED,
        B_EXP,
        B_GAIN,
        B_SHIFT,
        B_MAG1,
        B_MAG2,
        B_OUT
    } ahkc_back_state_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] bit_w;
        root = 64'd0;
        rem = v;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bit_w) begin
                rem = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0][30:0] gain_taps();
        logic [15:0][30:0] taps;
        logic [63:0] t;
        t = isqrt64(64'd1 << 59);
        for (int k = 15; k >= 0; k--) begin
            taps[k] = t[30:0];
            t = isqrt64(t << 30);
        end
        return taps;
    endfunction

    localparam logic [15:0][30:0] GAIN_TAPS = gain_taps();

    function automatic logic [31:0] log2_q16_const(input logic [63:0] x);
        logic [63:0] m;
        logic [31:0] p;
        logic [31:0] frac;
        p = 32'd0;
        frac = 32'd0;
        for (int i = 0; i < 40; i++) begin
            if ((x >> (i + 1)) != 64'd0) begin
                p = 32'(i + 1);
            end
        end
        m = x << (30 - p);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 32'd1;
                m = m >> 1;
            end
        end
        return (p << 16) + frac;
    endfunction

endpackage

### rtl/core/audio_hard_knee_compressor_top.sv
// Feed-forward hard-knee compressor for signed mono PCM samples.
// The input channel (s_valid, s_ready, s_sample_in) takes one sample per beat;
// the result channel (m_valid, m_ready, m_sample_out) returns one compressed
// sample per input beat, in order.
// Registers are written through cfg_wr_en, cfg_addr and cfg_wdata; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Writes to unused indexes are dropped.
// The front measures the level with a 16-step log2 iteration. The back updates
// the envelope and, when the envelope is above the threshold, forms the gain
// over 16 bit steps of a shared multiplier. The front takes a new sample only
// once it has pushed the last one to the queue, and the back pops the next one
// only after its last result has been accepted on m_ready.
// A two-entry queue separates front and back, so the front keeps taking beats
// while a result waits on m_ready; a stalled receiver eventually backs up s_ready.
// Synchronous active-low reset restores the register defaults and sets the
// envelope to 0 dBFS.
module audio_hard_knee_compressor_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_WIDTH-1:0] s_sample_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0] m_sample_out,
    input  logic                    cfg_wr_en,
    input  ahkc_pkg::ahkc_reg_t     cfg_addr,
    input  logic [23:0]             cfg_wdata
);
    import ahkc_pkg::*;

    localparam int QW = 32 + SAMPLE_WIDTH + 1;

    ahkc_cfg_t      cfg_reg, cfg_next;
    ahkc_q_status_t q_status;
    ahkc_q_ctrl_t   q_ctrl;

    logic                    f_push;
    logic signed [31:0]      f_level;
    logic [SAMPLE_WIDTH-1:0] f_mag;
    logic                    f_neg;
    logic                    b_pop;
    logic [QW-1:0]           q_rd;
    logic signed [31:0]      b_level;
    logic [SAMPLE_WIDTH-1:0] b_mag;
    logic                    b_neg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_db <= -16'sd2048;
            cfg_reg.inv_ratio    <= 16'd16384;
            cfg_reg.mkup_gain    <= 16'd5786;
            cfg_reg.atk_coef     <= 24'd16092528;
            cfg_reg.rel_coef     <= 24'd16776866;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_THRESHOLD: cfg_next.threshold_db = cfg_wdata[15:0];
                REG_INV_RATIO: cfg_next.inv_ratio = cfg_wdata[15:0];
                REG_MAKEUP:    cfg_next.mkup_gain = cfg_wdata[15:0];
                REG_ATTACK:    cfg_next.atk_coef = cfg_wdata;
                REG_RELEASE:   cfg_next.rel_coef = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
        q_ctrl.push = f_push;
        q_ctrl.pop = b_pop;
        b_level = q_rd[QW-1:SAMPLE_WIDTH+1];
        b_mag = q_rd[SAMPLE_WIDTH:1];
        b_neg = q_rd[0];
    end

    ahkc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .q_status    (q_status),
        .q_push      (f_push),
        .q_level     (f_level),
        .q_mag       (f_mag),
        .q_neg       (f_neg)
    );

    ahkc_fifo #(.WIDTH(QW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_data ({f_level, f_mag, f_neg}),
        .rd_data (q_rd),
        .status  (q_status)
    );

    ahkc_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .q_pop        (b_pop),
        .q_level      (b_level),
        .q_mag        (b_mag),
        .q_neg        (b_neg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !q_ctrl.push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !q_ctrl.pop)
        else $error("queue read while empty");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

### rtl/core/ahkc_front.sv
module ahkc_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SAMPLE_WIDTH-1:0]       s_sample_in,
    input  ahkc_pkg::ahkc_q_status_t      q_status,
    output logic                          q_push,
    output logic signed [31:0]            q_level,
    output logic [SAMPLE_WIDTH-1:0]       q_mag,
    output logic                          q_neg
);
    import ahkc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = $clog2(SW);
    localparam int LW = PW + 16;
    localparam int PRW = LW + 29;
    localparam logic [63:0] FS = (64'd1 << (SW - 1)) - 64'd1;
    localparam logic [31:0] LOG_FS_FULL = log2_q16_const(FS);
    localparam logic [LW-1:0] LOG_FS = LOG_FS_FULL[LW-1:0];

    ahkc_front_state_t state_reg, state_next;
    logic [SW-1:0]          mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic [30:0]            m_reg, m_next;
    logic [15:0]            frac_reg, frac_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic signed [PRW-1:0]  prod_reg, prod_next;

    logic [SW-1:0]          in_mag;
    logic [PW-1:0]          in_p;
    logic [SW+29:0]         in_ext;
    logic [61:0]            sq;
    logic [31:0]            sq_top;
    logic signed [LW:0]     diff;
    logic signed [PRW-1:0]  lvl_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        p_reg    <= p_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
    end

    always_comb begin
        in_mag = s_sample_in[SW-1] ? (~s_sample_in + 1'b1) : s_sample_in;
        in_p = '0;
        for (int i = 0; i < SW; i++) begin
            if (in_mag[i]) begin
                in_p = PW'(i);
            end
        end
        in_ext = {in_mag, 30'd0} >> in_p;
        sq = m_reg * m_reg;
        sq_top = sq[61:30];
        diff = $signed({1'b0, p_reg, frac_reg}) - $signed({1'b0, LOG_FS});
        lvl_wide = prod_reg >>> 16;

        state_next = state_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        m_next = m_reg;
        frac_next = frac_reg;
        p_next = p_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        s_ready = 1'b0;
        q_push = 1'b0;
        q_mag = mag_reg;
        q_neg = neg_reg;
        if (zero_reg || (lvl_wide < $signed(LEVEL_FLOOR_Q24))) begin
            q_level = LEVEL_FLOOR_Q24;
        end else begin
            q_level = lvl_wide[31:0];
        end

        unique case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mag_next = in_mag;
                    neg_next = s_sample_in[SW-1];
                    zero_next = (in_mag == '0);
                    p_next = in_p;
                    m_next = in_ext[30:0];
                    frac_next = '0;
                    cnt_next = '0;
                    state_next = F_LOG;
                end
            end
            F_LOG: begin
                frac_next = {frac_reg[14:0], sq_top[31]};
                m_next = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = F_SCALE;
                end
            end
            F_SCALE: begin
                prod_next = diff * $signed({1'b0, DB_PER_OCTAVE_Q24});
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_status.full) begin
                    q_push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

endmodule

### rtl/core/ahkc_fifo.sv
module ahkc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ahkc_pkg::ahkc_q_ctrl_t   ctrl,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data,
    output ahkc_pkg::ahkc_q_status_t status
);
    import ahkc_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (ctrl.push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ ctrl.push;
        rd_ptr_next = rd_ptr_reg ^ ctrl.pop;
        count_next = count_reg + {1'b0, ctrl.push} - {1'b0, ctrl.pop};
        status.full = (count_reg == 2'd2);
        status.empty = (count_reg == 2'd0);
        rd_data = mem_reg[rd_ptr_reg];
    end

endmodule

### rtl/core/ahkc_back.sv
module ahkc_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ahkc_pkg::ahkc_cfg_t      cfg,
    input  ahkc_pkg::ahkc_q_status_t q_status,
    output logic                     q_pop,
    input  logic signed [31:0]       q_level,
    input  logic [SAMPLE_WIDTH-1:0]  q_mag,
    input  logic                     q_neg,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SAMPLE_WIDTH-1:0]  m_sample_out
);
    import ahkc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam logic [SW+4:0] FS = (SW+5)'((64'd1 << (SW - 1)) - 64'd1);

    ahkc_back_state_t state_reg, state_next;
    logic signed [31:0] env_reg, env_next;
    logic               valid_reg, valid_next;
    logic signed [31:0] level_reg, level_next;
    logic [SW-1:0]      mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [23:0]        coeff_reg, coeff_next;
    logic signed [57:0] acc_reg, acc_next;
    logic [32:0]        over_reg, over_next;
    logic [33:0]        red_reg, red_next;
    logic [23:0]        e_reg, e_next;
    logic [30:0]        g_reg, g_next;
    logic [3:0]         k_reg, k_next;
    logic [SW+10:0]     big_reg, big_next;
    logic [SW-1:0]      out_reg, out_next;

    logic signed [56:0] p1;
    logic signed [56:0] p2;
    logic signed [57:0] acc_sh;
    logic signed [31:0] env_new;
    logic signed [31:0] thr;
    logic [49:0]        rp;
    logic [63:0]        ep;
    logic [61:0]        gp;
    logic [SW+30:0]     mp;
    logic [SW+26:0]     op;
    logic [SW+4:0]      mag_full;
    logic [SW-1:0]      mag_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            env_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            env_reg   <= env_next;
            valid_reg <= valid_next;
        end
        level_reg <= level_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        coeff_reg <= coeff_next;
        acc_reg   <= acc_next;
        over_reg  <= over_next;
        red_reg   <= red_next;
        e_reg     <= e_next;
        g_reg     <= g_next;
        k_reg     <= k_next;
        big_reg   <= big_next;
        out_reg   <= out_next;
    end

    always_comb begin
        p1 = $signed({1'b0, coeff_reg}) * env_reg;
        p2 = $signed({1'b0, 25'h100_0000 - {1'b0, coeff_reg}}) * level_reg;
        acc_sh = acc_reg >>> 24;
        env_new = acc_sh[31:0];
        thr = {cfg.threshold_db, 16'h0000};
        rp = (17'h1_0000 - {1'b0, cfg.inv_ratio}) * over_reg;
        ep = red_reg * LOG2_TEN_OVER_20_Q32;
        gp = g_reg * GAIN_TAPS[k_reg] + 62'h2000_0000;
        mp = mag_reg * g_reg;
        op = big_reg * cfg.mkup_gain;
        mag_full = op[SW+26:22];
        mag_c = (mag_full > FS) ? FS[SW-1:0] : mag_full[SW-1:0];

        state_next = state_reg;
        env_next = env_reg;
        valid_next = valid_reg;
        level_next = level_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        coeff_next = coeff_reg;
        acc_next = acc_reg;
        over_next = over_reg;
        red_next = red_reg;
        e_next = e_reg;
        g_next = g_reg;
        k_next = k_reg;
        big_next = big_reg;
        out_next = out_reg;
        q_pop = 1'b0;

        unique case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    q_pop = 1'b1;
                    level_next = q_level;
                    mag_next = q_mag;
                    neg_next = q_neg;
                    coeff_next = (q_level > env_reg) ? cfg.atk_coef : cfg.rel_coef;
                    state_next = B_ENV1;
                end
            end
            B_ENV1: begin
                acc_next = {p1[56], p1};
                state_next = B_ENV2;
            end
            B_ENV2: begin
                acc_next = acc_reg + {p2[56], p2} + 58'sd8388608;
                state_next = B_ENV3;
            end
            B_ENV3: begin
                env_next = env_new;
                over_next = 33'({env_new[31], env_new} - {thr[31], thr});
                if (env_new > thr) begin
                    state_next = B_RED;
                end else begin
                    g_next = GAIN_ONE_Q30;
                    state_next = B_MAG1;
                end
            end
            B_RED: begin
                red_next = rp[49:16];
                state_next = B_EXP;
            end
            B_EXP: begin
                e_next = ep[63:40];
                g_next = GAIN_ONE_Q30;
                k_next = 4'd15;
                state_next = B_GAIN;
            end
            B_GAIN: begin
                if (e_reg[k_reg]) begin
                    g_next = gp[60:30];
                end
                k_next = k_reg - 4'd1;
                if (k_reg == 4'd0) begin
                    state_next = B_SHIFT;
                end
            end
            B_SHIFT: begin
                if (e_reg[23:16] >= 8'd31) begin
                    g_next = '0;
                end else begin
                    g_next = g_reg >> e_reg[20:16];
                end
                state_next = B_MAG1;
            end
            B_MAG1: begin
                big_next = mp[SW+30:20];
                state_next = B_MAG2;
            end
            B_MAG2: begin
                out_next = neg_reg ? (~mag_c + 1'b1) : mag_c;
                valid_next = 1'b1;
                state_next = B_OUT;
            end
            B_OUT: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        m_valid = valid_reg;
        m_sample_out = out_reg;
    end

endmodule

### tb/sv/tb_audio_hard_knee_compressor_top.sv
`timescale 1ns / 1ps

module tb_audio_hard_knee_compressor_top;
    import ahkc_pkg::*;

    localparam int SW = 16;
    localparam longint FULL_SCALE = 32767;
    localparam longint LEVEL_FLOOR = -64'sd1677721600;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [SW-1:0] s_sample_in;
    logic m_valid;
    logic m_ready;
    logic [SW-1:0] m_sample_out;
    logic cfg_wr_en;
    ahkc_reg_t cfg_addr;
    logic [23:0] cfg_wdata;

    audio_hard_knee_compressor_top #(.SAMPLE_WIDTH(SW)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample_out(m_sample_out),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Shadow of the register file and the envelope, in the block's formats.
    logic signed [15:0] thr_q88;
    logic [15:0] inv_ratio_q16;
    logic [15:0] makeup_q412;
    logic [23:0] attack_q24;
    logic [23:0] release_q24;
    logic signed [31:0] env_q824;

    logic [SW-1:0] compressed_fifo[$];
    int errors;
    int pending;
    bit hold_req;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint floor_sh(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint sqrt_floor(longint unsigned v);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint log2_fix(longint unsigned x);
        int p;
        longint unsigned m;
        longint frac;
        p = 0;
        frac = 0;
        while (p < 40 && (x >> (p + 1)) != 0) p++;
        m = x << (30 - p);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(p) * 65536 + frac;
    endfunction

    function automatic longint unsigned gain_of_exp(longint unsigned e);
        longint unsigned g, t, whole;
        g = 64'd1 << 30;
        t = sqrt_floor(64'd1 << 59);
        whole = e >> 16;
        for (int k = 15; k >= 0; k--) begin
            if ((e >> k) & 1) g = (g * t + (64'd1 << 29)) >> 30;
            t = sqrt_floor(t << 30);
        end
        if (whole >= 31) return 0;
        return g >> whole;
    endfunction

    function automatic logic [SW-1:0] compress_sample(logic [SW-1:0] raw);
        bit neg;
        longint unsigned mag_in, g, mag, over, red, e;
        longint level, coeff, env, thr;
        neg = raw[SW-1];
        mag_in = neg ? (64'd65536 - raw) : raw;
        if (mag_in == 0) begin
            level = LEVEL_FLOOR;
        end else begin
            level = floor_sh((log2_fix(mag_in) - log2_fix(FULL_SCALE)) * 101008905, 16);
            if (level < LEVEL_FLOOR) level = LEVEL_FLOOR;
        end
        coeff = (level > longint'(env_q824)) ? longint'(attack_q24) : longint'(release_q24);
        env = floor_sh(coeff * longint'(env_q824) + ((64'sd1 << 24) - coeff) * level
                       + (64'sd1 << 23), 24);
        env_q824 = env[31:0];
        thr = longint'(thr_q88) * 65536;
        if (env > thr) begin
            over = env - thr;
            red = ((64'd65536 - inv_ratio_q16) * over) >> 16;
            e = (red * 64'd713378626) >> 40;
            g = gain_of_exp(e);
        end else begin
            g = 64'd1 << 30;
        end
        mag = (mag_in * g) >> 20;
        mag = (mag * makeup_q412) >> 22;
        if (mag > FULL_SCALE) mag = FULL_SCALE;
        return neg ? SW'(-mag) : SW'(mag);
    endfunction

    task automatic write_reg(ahkc_reg_t idx, logic [23:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_q88 = val[15:0];
            REG_INV_RATIO: inv_ratio_q16 = val[15:0];
            REG_MAKEUP:    makeup_q412 = val[15:0];
            REG_ATTACK:    attack_q24 = val;
            REG_RELEASE:   release_q24 = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return;
        if (r < 95) repeat ($urandom_range(1, 4)) @(negedge aclk);
        else repeat ($urandom_range(20, 90)) @(negedge aclk);
    endtask

    // Sends one beat; the expectation is queued when the beat is accepted.
    task automatic send_sample(logic [SW-1:0] smp, bit use_exp, logic [SW-1:0] exp_val);
        logic [SW-1:0] pred;
        s_valid = 1'b1;
        s_sample_in = smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = compress_sample(smp);
        if (use_exp && pred !== exp_val) begin
            $display("%0t: predictor disagrees with table: expected %0d actual %0d",
                     $time, $signed(exp_val), $signed(pred));
            errors++;
        end
        compressed_fifo.push_back(pred);
        pending++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    typedef struct {
        logic [SW-1:0] smp;
        bit use_exp;
        logic [SW-1:0] exp_val;
    } stim_row_t;

    stim_row_t directed_rows[] = '{
        '{16'sd0, 1'b1, 16'sd0},
        '{16'sh7FFF, 1'b0, 16'd0},
        '{16'sh8000, 1'b0, 16'd0},
        '{16'sh8001, 1'b0, 16'd0},
        '{16'sd1, 1'b0, 16'd0},
        '{16'hFFFF, 1'b0, 16'd0},
        '{16'sh4000, 1'b0, 16'd0},
        '{16'hC000, 1'b0, 16'd0},
        '{16'sd0, 1'b1, 16'sd0},
        '{16'h5555, 1'b0, 16'd0},
        '{16'hAAAA, 1'b0, 16'd0},
        '{16'sd100, 1'b0, 16'd0}
    };

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 5) begin
                m_ready <= 1'b0;
                hold_left = $urandom_range(10, 60);
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge aclk) begin
        logic [SW-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (compressed_fifo.size() == 0) begin
                $display("%0t: unexpected beat: expected none actual %0d",
                         $time, $signed(m_sample_out));
                errors++;
            end else begin
                want = compressed_fifo.pop_front();
                pending--;
                if (m_sample_out !== want) begin
                    $display("%0t: sample_out mismatch: expected %0d actual %0d",
                             $time, $signed(want), $signed(m_sample_out));
                    errors++;
                end
            end
        end
    end

    task automatic random_block(int n, bit small_amp);
        logic [SW-1:0] smp;
        for (int i = 0; i < n; i++) begin
            random_gap();
            if (small_amp && $urandom_range(0, 1)) smp = SW'($urandom_range(0, 400) - 200);
            else smp = SW'($urandom);
            send_sample(smp, 1'b0, '0);
        end
    endtask

    initial begin
        errors = 0;
        pending = 0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample_in = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_THRESHOLD;
        cfg_wdata = '0;
        thr_q88 = -16'sd2048;
        inv_ratio_q16 = 16'd16384;
        makeup_q412 = 16'd5786;
        attack_q24 = 24'd16092528;
        release_q24 = 24'd16776866;
        env_q824 = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            random_gap();
            send_sample(directed_rows[i].smp, directed_rows[i].use_exp,
                        directed_rows[i].exp_val);
        end
        wait_idle();

        // Fast envelope, full compression, unity makeup.
        write_reg(REG_ATTACK, 24'd0);
        write_reg(REG_RELEASE, 24'd0);
        write_reg(REG_INV_RATIO, 16'd0);
        write_reg(REG_MAKEUP, 16'd4096);
        write_reg(REG_THRESHOLD, 16'h8000);
        send_sample(16'h7FFF, 1'b0, '0);
        send_sample(16'h8000, 1'b0, '0);
        send_sample(16'sd0, 1'b1, 16'sd0);
        random_block(60, 1'b0);
        wait_idle();

        // Maximum makeup, most-positive threshold, slowest envelope.
        write_reg(REG_THRESHOLD, 16'h7FFF);
        write_reg(REG_INV_RATIO, 16'hFFFF);
        write_reg(REG_MAKEUP, 16'hFFFF);
        write_reg(REG_ATTACK, 24'hFFFFFF);
        write_reg(REG_RELEASE, 24'hFFFFFF);
        random_block(60, 1'b1);
        wait_idle();

        // Receiver holds off while the sender keeps offering beats.
        hold_req = 1'b1;
        random_block(40, 1'b0);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_THRESHOLD, 24'($urandom));
            write_reg(REG_INV_RATIO, 24'($urandom));
            write_reg(REG_MAKEUP, 24'($urandom_range(0, 16384)));
            write_reg(REG_ATTACK, 24'($urandom));
            write_reg(REG_RELEASE, 24'($urandom));
            random_block(60, ph[0]);
            wait_idle();
        end

        write_reg(REG_THRESHOLD, 16'hF800);
        write_reg(REG_INV_RATIO, 16'd16384);
        write_reg(REG_MAKEUP, 16'd0);
        write_reg(REG_ATTACK, 24'd16092528);
        write_reg(REG_RELEASE, 24'd16776866);
        random_block(10, 1'b0);
        wait_idle();
        write_reg(REG_MAKEUP, 16'd5786);
        random_block(20, 1'b0);
        wait_idle();

        if (errors == 0 && compressed_fifo.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
